### hdl/rotozoom_texel_fetch_defines.svh
// Assertion macros for the rotozoom texel fetch block.
// Used by the top level only; compiled out when SYNTHESIS is defined.
`ifndef ROTOZOOM_TEXEL_FETCH_DEFINES_SVH
`define ROTOZOOM_TEXEL_FETCH_DEFINES_SVH

`ifndef SYNTHESIS
// condition must hold at every edge out of reset
`define RZ_ASSERT_HOLD(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rotozoom check failed");
// consequent must hold in the cycle after the antecedent
`define RZ_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rotozoom check failed");
`else
`define RZ_ASSERT_HOLD(label, cond)
`define RZ_ASSERT_NEXT(label, pre, post)
`endif

`endif

### hdl/rz_pkg.sv
// Shared types, constants and elaboration-time table builders for rotozoom.
// No dependencies.
`timescale 1ns / 1ps

package rz_pkg;

  localparam int TEXTURE_SIDE = 256;
  localparam int ANGLE_STEPS  = 1024;
  localparam int ANGLE_W      = $clog2(ANGLE_STEPS);
  localparam int TEX_W        = $clog2(TEXTURE_SIDE);     // texel coordinate bits
  localparam int DIM_W        = TEX_W + 1;                // width/height register bits
  localparam int ADDR_W       = 2 * TEX_W;
  localparam int RGB_W        = 24;
  localparam int WORD_W       = 32;
  localparam int PIX_W        = 8;
  localparam int DIFF_W       = PIX_W + 1;
  localparam int TRIG_W       = 16;                       // Q1.14 plus sign, holds +-16384
  localparam int ZOOM_W       = 14;
  localparam int PROD_W       = DIFF_W + TRIG_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int SCALE_W      = SUM_W + ZOOM_W + 1;
  localparam int FRAC_BITS    = 26;
  localparam int COORD_W      = SCALE_W - FRAC_BITS;
  localparam int MAG_W        = 11;                       // |coordinate| <= 2040
  localparam int WRAP_STEPS   = 4;                        // remainder steps per stage
  localparam int WRAP_STAGES  = (MAG_W + WRAP_STEPS - 1) / WRAP_STEPS;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [ZOOM_W-1:0] ZOOM_RESET   = 14'd4096;
  localparam logic [PIX_W-1:0]  CENTER_RESET = 8'd96;
  localparam logic [DIM_W-1:0]  DIM_RESET    = DIM_W'(TEXTURE_SIDE);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE  = 3'd0,
    REG_ZOOM   = 3'd1,
    REG_CENTER = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  typedef struct packed {
    logic full;
    logic empty;
  } obuf_stat_t;

  typedef logic signed [TRIG_W-1:0] trig_tab_t [ANGLE_STEPS];

  localparam longint Q28_ONE = 64'sd1 << 28;
  localparam longint PI_Q28  = 64'sd843314857;

  // Taylor term denominators: (2n)(2n+1) for sine, (2n-1)(2n) for cosine
  localparam longint SIN_DEN [14] = '{6, 20, 42, 72, 110, 156, 210,
                                      272, 342, 420, 506, 600, 702, 812};
  localparam longint COS_DEN [14] = '{2, 12, 30, 56, 90, 132, 182,
                                      240, 306, 380, 462, 552, 650, 756};

  // round half away from zero from Q4.28 to Q1.14, clamped
  function automatic logic signed [TRIG_W-1:0] to_q14(longint v);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag + 64'sd8192) / 64'sd16384;
    if (q > 64'sd16384) q = 64'sd16384;
    return TRIG_W'((v < 0) ? -q : q);
  endfunction

  // Taylor series table, evaluated at elaboration
  function automatic trig_tab_t build_trig(bit want_cos);
    trig_tab_t tab;
    longint kk, th, st, ss, ct, cs;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      kk = (k <= ANGLE_STEPS / 2) ? longint'(k) : longint'(k - ANGLE_STEPS);
      th = (2 * PI_Q28 * kk) / ANGLE_STEPS;
      st = th;
      ss = th;
      ct = Q28_ONE;
      cs = Q28_ONE;
      for (int n = 0; n < 14; n++) begin
        st = -((((st * th) / Q28_ONE) * th) / Q28_ONE) / SIN_DEN[n];
        ss += st;
        ct = -((((ct * th) / Q28_ONE) * th) / Q28_ONE) / COS_DEN[n];
        cs += ct;
      end
      tab[k] = want_cos ? to_q14(cs) : to_q14(ss);
    end
    return tab;
  endfunction

endpackage

### hdl/rz_trig_rom.sv
// Sine/cosine ROM, registered read of the current rotation angle.
// Depends on rz_pkg for the table builder.
`timescale 1ns / 1ps

module rz_trig_rom (
  input  logic                                  clk,
  input  logic [rz_pkg::ANGLE_W-1:0]            angle,
  output logic signed [rz_pkg::TRIG_W-1:0]      sin_q,
  output logic signed [rz_pkg::TRIG_W-1:0]      cos_q
);

  localparam rz_pkg::trig_tab_t SIN_TAB = rz_pkg::build_trig(1'b0);
  localparam rz_pkg::trig_tab_t COS_TAB = rz_pkg::build_trig(1'b1);

  // registered lookup; the user must move angle only while idle, not enforced here
  always_ff @(posedge clk) begin
    sin_q <= SIN_TAB[angle];
    cos_q <= COS_TAB[angle];
  end

endmodule

### hdl/rz_wrap.sv
// Pipelined unsigned remainder: magnitude mod a 1..TEXTURE_SIDE modulus.
// Restoring steps, WRAP_STEPS per stage; depends on rz_pkg.
`timescale 1ns / 1ps

module rz_wrap (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rz_pkg::MAG_W-1:0]    mag,
  input  logic [rz_pkg::DIM_W-1:0]    modulus,
  output logic [rz_pkg::DIM_W-1:0]    rem
);

  localparam int NST   = rz_pkg::WRAP_STAGES;
  localparam int SPS   = rz_pkg::WRAP_STEPS;
  localparam int PAD_W = NST * SPS;
  localparam int REM_W = rz_pkg::DIM_W;

  logic [REM_W-1:0] rem_q [NST];
  logic [PAD_W-1:0] mag_q [NST];
  logic [PAD_W-1:0] mag_pad;

  // leading zeros do not change the remainder
  assign mag_pad = PAD_W'(mag);

  for (genvar j = 0; j < NST; j++) begin : g_stage
    logic [REM_W-1:0] r_in;
    logic [REM_W-1:0] r_out;
    logic [PAD_W-1:0] m_in;

    if (j == 0) begin : g_first
      assign r_in = '0;
      assign m_in = mag_pad;
    end else begin : g_next
      assign r_in = rem_q[j-1];
      assign m_in = mag_q[j-1];
    end

    // shift in one bit, subtract modulus if it fits
    always_comb begin
      logic [REM_W:0] t;
      r_out = r_in;
      for (int i = 0; i < SPS; i++) begin
        t = {r_out, m_in[PAD_W-1-j*SPS-i]};
        if (t >= {1'b0, modulus}) t = t - {1'b0, modulus};
        r_out = t[REM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= r_out;
        mag_q[j] <= m_in;
      end
    end
  end

  assign rem = rem_q[NST-1];

endmodule

### hdl/rz_obuf.sv
// Two-word output buffer that decouples the pipeline from the sink.
// Depends on rz_pkg for the status struct.
`timescale 1ns / 1ps

module rz_obuf (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [rz_pkg::WORD_W-1:0]    push_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rz_pkg::WORD_W-1:0]    pixel_word,
  output rz_pkg::obuf_stat_t           stat
);

  logic [rz_pkg::WORD_W-1:0] buf_word [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != 2'd0);
  assign pixel_word = buf_word[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_word[wr_ptr] <= push_word;
  end

endmodule

### hdl/rotozoom_texel_fetch.sv
// Rotozoom texel fetch top level: config, arithmetic pipeline, texture store.
// Depends on rz_pkg, rz_trig_rom, rz_wrap, rz_obuf and the defines header.
//
//  channel | signals                                            | dir
//  --------+----------------------------------------------------+-----
//  input   | in_valid in_ready kind texel_address texel_rgb      | in
//          | pixel_x pixel_y                                    |
//  output  | out_valid out_ready pixel_word                     | out
//  config  | cfg_valid cfg_ready cfg_index cfg_data             | in
//
// One word enters per cycle while the output buffer is not full; a pixel word passes
// 11 pipeline stages incl. the store read, then the output buffer.
// Loads write the store at the read stage, so later pixels see them in order.
// Reset (rst, synchronous) clears valids and sets the registers to defaults.
// A full two-word output buffer freezes every stage; nothing is lost.
`timescale 1ns / 1ps
`include "rotozoom_texel_fetch_defines.svh"

module rotozoom_texel_fetch (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [15:0]                       texel_address,
  input  logic [rz_pkg::RGB_W-1:0]          texel_rgb,
  input  logic [rz_pkg::PIX_W-1:0]          pixel_x,
  input  logic [rz_pkg::PIX_W-1:0]          pixel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rz_pkg::WORD_W-1:0]         pixel_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rz_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rz_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NW = rz_pkg::WRAP_STAGES;

  // config registers
  logic [rz_pkg::ANGLE_W-1:0] angle;
  logic [rz_pkg::ZOOM_W-1:0]  zoom;
  logic [rz_pkg::PIX_W-1:0]   center;
  logic [rz_pkg::DIM_W-1:0]   width_raw, height_raw, wd, ht;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle      <= '0;
      zoom       <= rz_pkg::ZOOM_RESET;
      center     <= rz_pkg::CENTER_RESET;
      width_raw  <= rz_pkg::DIM_RESET;
      height_raw <= rz_pkg::DIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rz_pkg::REG_ANGLE:  angle      <= cfg_data[rz_pkg::ANGLE_W-1:0];
        rz_pkg::REG_ZOOM:   zoom       <= cfg_data[rz_pkg::ZOOM_W-1:0];
        rz_pkg::REG_CENTER: center     <= cfg_data[rz_pkg::PIX_W-1:0];
        rz_pkg::REG_WIDTH:  width_raw  <= cfg_data[rz_pkg::DIM_W-1:0];
        rz_pkg::REG_HEIGHT: height_raw <= cfg_data[rz_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate dimensions into 1..TEXTURE_SIDE
  function automatic logic [rz_pkg::DIM_W-1:0] clamp_dim(logic [rz_pkg::DIM_W-1:0] d);
    if (d == '0) return rz_pkg::DIM_W'(1);
    if (d > rz_pkg::DIM_RESET) return rz_pkg::DIM_RESET;
    return d;
  endfunction

  always_ff @(posedge clk) begin
    wd <= clamp_dim(width_raw);
    ht <= clamp_dim(height_raw);
  end

  logic signed [rz_pkg::TRIG_W-1:0] sin_q, cos_q;

  rz_trig_rom u_rom (
    .clk   (clk),
    .angle (angle),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  // global advance: stop only when the output buffer is full
  rz_pkg::obuf_stat_t ob_stat;
  logic adv;
  assign adv      = !ob_stat.full;
  assign in_ready = adv;

  // stage 1: centre subtract
  logic v1, k1;
  logic [15:0] a1;
  logic [rz_pkg::RGB_W-1:0] c1;
  logic signed [rz_pkg::DIFF_W-1:0] sx1, sy1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k1  <= kind;
      a1  <= texel_address;
      c1  <= texel_rgb;
      sx1 <= $signed({1'b0, pixel_x}) - $signed({1'b0, center});
      sy1 <= $signed({1'b0, pixel_y}) - $signed({1'b0, center});
    end
  end

  // stage 2: rotation products
  logic v2, k2;
  logic [15:0] a2;
  logic [rz_pkg::RGB_W-1:0] c2;
  logic signed [rz_pkg::PROD_W-1:0] pxc, pys, pyc, pxs;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k2  <= k1;
      a2  <= a1;
      c2  <= c1;
      pxc <= rz_pkg::PROD_W'(sx1) * rz_pkg::PROD_W'(cos_q);
      pys <= rz_pkg::PROD_W'(sy1) * rz_pkg::PROD_W'(sin_q);
      pyc <= rz_pkg::PROD_W'(sy1) * rz_pkg::PROD_W'(cos_q);
      pxs <= rz_pkg::PROD_W'(sx1) * rz_pkg::PROD_W'(sin_q);
    end
  end

  // stage 3: rotated sums
  logic v3, k3;
  logic [15:0] a3;
  logic [rz_pkg::RGB_W-1:0] c3;
  logic signed [rz_pkg::SUM_W-1:0] su, sv;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k3 <= k2;
      a3 <= a2;
      c3 <= c2;
      su <= rz_pkg::SUM_W'(pxc) + rz_pkg::SUM_W'(pys);
      sv <= rz_pkg::SUM_W'(pyc) - rz_pkg::SUM_W'(pxs);
    end
  end

  // stage 4: zoom
  logic v4, k4;
  logic [15:0] a4;
  logic [rz_pkg::RGB_W-1:0] c4;
  logic signed [rz_pkg::SCALE_W-1:0] uu, vv;
  logic signed [rz_pkg::ZOOM_W:0] zs;
  assign zs = $signed({1'b0, zoom});

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k4 <= k3;
      a4 <= a3;
      c4 <= c3;
      uu <= rz_pkg::SCALE_W'(su) * rz_pkg::SCALE_W'(zs);
      vv <= rz_pkg::SCALE_W'(sv) * rz_pkg::SCALE_W'(zs);
    end
  end

  // stage 5: truncate toward zero, split sign and magnitude
  function automatic logic signed [rz_pkg::COORD_W-1:0] trunc_q(
    logic signed [rz_pkg::SCALE_W-1:0] x);
    logic signed [rz_pkg::COORD_W-1:0] q;
    q = x[rz_pkg::SCALE_W-1:rz_pkg::FRAC_BITS];
    if (x[rz_pkg::SCALE_W-1] && (x[rz_pkg::FRAC_BITS-1:0] != '0))
      q = q + rz_pkg::COORD_W'(1);
    return q;
  endfunction

  logic signed [rz_pkg::COORD_W-1:0] tu, tv;
  assign tu = trunc_q(uu);
  assign tv = trunc_q(vv);

  logic v5, k5, negu, negv;
  logic [15:0] a5;
  logic [rz_pkg::RGB_W-1:0] c5;
  logic [rz_pkg::MAG_W-1:0] magu, magv;
  logic [rz_pkg::COORD_W-1:0] abs_u, abs_v;
  assign abs_u = tu[rz_pkg::COORD_W-1] ? -tu : tu;
  assign abs_v = tv[rz_pkg::COORD_W-1] ? -tv : tv;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k5   <= k4;
      a5   <= a4;
      c5   <= c4;
      negu <= tu[rz_pkg::COORD_W-1];
      negv <= tv[rz_pkg::COORD_W-1];
      magu <= abs_u[rz_pkg::MAG_W-1:0];
      magv <= abs_v[rz_pkg::MAG_W-1:0];
    end
  end

  // stages 6..: remainder units with sideband shift line
  logic [rz_pkg::DIM_W-1:0] remu, remv;

  rz_wrap u_wrap_x (
    .clk (clk), .en (adv), .mag (magu), .modulus (wd), .rem (remu)
  );
  rz_wrap u_wrap_y (
    .clk (clk), .en (adv), .mag (magv), .modulus (ht), .rem (remv)
  );

  logic wv [NW];
  logic wk [NW];
  logic wnu [NW];
  logic wnv [NW];
  logic [15:0] wa [NW];
  logic [rz_pkg::RGB_W-1:0] wc [NW];

  for (genvar j = 0; j < NW; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) wv[j] <= 1'b0;
      else if (adv) wv[j] <= (j == 0) ? v5 : wv[(j == 0) ? 0 : j-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        wk[j]  <= (j == 0) ? k5   : wk[(j == 0) ? 0 : j-1];
        wnu[j] <= (j == 0) ? negu : wnu[(j == 0) ? 0 : j-1];
        wnv[j] <= (j == 0) ? negv : wnv[(j == 0) ? 0 : j-1];
        wa[j]  <= (j == 0) ? a5   : wa[(j == 0) ? 0 : j-1];
        wc[j]  <= (j == 0) ? c5   : wc[(j == 0) ? 0 : j-1];
      end
    end
  end

  // stage 9: non-negative remainder
  logic v9, k9;
  logic [15:0] a9;
  logic [rz_pkg::RGB_W-1:0] c9;
  logic [rz_pkg::TEX_W-1:0] tx, ty;
  logic [rz_pkg::DIM_W-1:0] fx, fy;
  assign fx = (wnu[NW-1] && remu != '0) ? wd - remu : remu;
  assign fy = (wnv[NW-1] && remv != '0) ? ht - remv : remv;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (adv) v9 <= wv[NW-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k9 <= wk[NW-1];
      a9 <= wa[NW-1];
      c9 <= wc[NW-1];
      tx <= fx[rz_pkg::TEX_W-1:0];
      ty <= fy[rz_pkg::TEX_W-1:0];
    end
  end

  // stage 10: store address, texel address for loads, row times stride plus column for pixels
  logic v10, k10;
  logic [rz_pkg::ADDR_W-1:0] a10;
  logic [rz_pkg::RGB_W-1:0] c10;
  logic [rz_pkg::ADDR_W-1:0] row_addr;
  assign row_addr = rz_pkg::ADDR_W'(ty) * rz_pkg::ADDR_W'(wd) + rz_pkg::ADDR_W'(tx);

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (adv) v10 <= v9;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k10 <= k9;
      c10 <= c9;
      a10 <= (k9 == rz_pkg::KIND_LOAD) ? a9[rz_pkg::ADDR_W-1:0]
                                        : row_addr[rz_pkg::ADDR_W-1:0];
    end
  end

  // stage 11: texture store, write for loads, registered read for pixels
  logic [rz_pkg::RGB_W-1:0] store [2**rz_pkg::ADDR_W];
  logic [rz_pkg::RGB_W-1:0] rd_data;
  logic v11;

  always_ff @(posedge clk) begin
    if (adv && v10) begin
      if (k10 == rz_pkg::KIND_LOAD) store[a10] <= c10;
      else rd_data <= store[a10];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (adv) v11 <= v10 && (k10 == rz_pkg::KIND_PIXEL);
  end

  rz_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (adv && v11),
    .push_word  ({rd_data, 8'h00}),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_word (pixel_word),
    .stat       (ob_stat)
  );

  // checks
  `RZ_ASSERT_HOLD(a_full_blocks_input, !(ob_stat.full && in_ready))
  `RZ_ASSERT_HOLD(a_empty_no_valid, ob_stat.empty == !out_valid)
  `RZ_ASSERT_NEXT(a_stall_freezes, !adv, $stable(v11) && $stable(v10))
  `RZ_ASSERT_NEXT(a_load_no_word, adv && v10 && (k10 == rz_pkg::KIND_LOAD), !v11)

endmodule
